[sv/tbp_pkg.sv]
// Shared sizes, table access types and counter helpers of the tournament branch predictor.
package tbp_pkg;

  localparam int unsigned LOCAL_ENTRIES  = 1024;
  localparam int unsigned GLOBAL_ENTRIES = 4096;
  localparam int unsigned LIDX_W = $clog2(LOCAL_ENTRIES);
  localparam int unsigned GIDX_W = $clog2(GLOBAL_ENTRIES);
  localparam int unsigned CLR_W  = (LIDX_W > GIDX_W) ? LIDX_W : GIDX_W;
  localparam int unsigned ADDR_W = 32;

  localparam logic [2:0] LOCAL_TAKEN_ABOVE   = 3'd3;
  localparam logic [2:0] LOCAL_MAX           = 3'd7;
  localparam logic [1:0] TWO_BIT_TAKEN_ABOVE = 2'd1;
  localparam logic [1:0] TWO_BIT_MAX         = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HIST  = 4'b0100,
    ST_CNT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic              en;
    logic [LIDX_W-1:0] row;
    logic [LIDX_W-1:0] hist;
    logic [LIDX_W-1:0] cidx;
    logic [2:0]        cnt;
  } lcl_wr_t;

  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] idx;
    logic [1:0]        gcnt;
    logic [1:0]        ccnt;
    logic              shift;
    logic              taken;
  } glb_wr_t;

  function automatic logic [2:0] sat3(input logic [2:0] v, input logic up);
    logic [2:0] r;
    if (up) begin
      r = (v < LOCAL_MAX) ? v + 3'd1 : LOCAL_MAX;
    end else begin
      r = (v != 3'd0) ? v - 3'd1 : 3'd0;
    end
    return r;
  endfunction

  function automatic logic [1:0] sat2(input logic [1:0] v, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (v < TWO_BIT_MAX) ? v + 2'd1 : TWO_BIT_MAX;
    end else begin
      r = (v != 2'd0) ? v - 2'd1 : 2'd0;
    end
    return r;
  endfunction

endpackage

[sv/tbp_local.sv]
// Local history table and local counter table, read in two chained steps.
module tbp_local (
  input  logic                          clk_i,
  input  logic                          hist_rd_i,
  input  logic [tbp_pkg::LIDX_W-1:0]    row_i,
  input  logic                          cnt_rd_i,
  input  tbp_pkg::lcl_wr_t              wr_i,
  output logic [tbp_pkg::LIDX_W-1:0]    hist_o,
  output logic [2:0]                    cnt_o
);
  import tbp_pkg::*;

  logic [LIDX_W-1:0] hist_mem [LOCAL_ENTRIES];
  logic [2:0]        cnt_mem  [LOCAL_ENTRIES];
  logic [LIDX_W-1:0] hist_q;
  logic [2:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      hist_mem[wr_i.row] <= wr_i.hist;
    end
    if (hist_rd_i) begin
      hist_q <= hist_mem[row_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cnt_mem[wr_i.cidx] <= wr_i.cnt;
    end
    if (cnt_rd_i) begin
      cnt_q <= cnt_mem[hist_q];
    end
  end

  assign hist_o = hist_q;
  assign cnt_o  = cnt_q;

endmodule

[sv/tbp_global.sv]
// Path history register with the global counter and choice counter tables.
module tbp_global (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_i,
  input  tbp_pkg::glb_wr_t              wr_i,
  output logic [tbp_pkg::GIDX_W-1:0]    path_o,
  output logic [1:0]                    gcnt_o,
  output logic [1:0]                    ccnt_o
);
  import tbp_pkg::*;

  logic [1:0]        gcnt_mem [GLOBAL_ENTRIES];
  logic [1:0]        ccnt_mem [GLOBAL_ENTRIES];
  logic [GIDX_W-1:0] path_q;
  logic [GIDX_W-1:0] path_d;
  logic [1:0]        gcnt_q;
  logic [1:0]        ccnt_q;

  assign path_d = {wr_i.idx[GIDX_W-2:0], wr_i.taken};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q <= '0;
    end else if (wr_i.en && wr_i.shift) begin
      path_q <= path_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      gcnt_mem[wr_i.idx] <= wr_i.gcnt;
    end
    if (rd_i) begin
      gcnt_q <= gcnt_mem[path_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ccnt_mem[wr_i.idx] <= wr_i.ccnt;
    end
    if (rd_i) begin
      ccnt_q <= ccnt_mem[path_q];
    end
  end

  assign path_o = path_q;
  assign gcnt_o = gcnt_q;
  assign ccnt_o = ccnt_q;

endmodule

[sv/tournament_branch_predictor.sv]
// Top level of the tournament branch predictor: control, write-back and output register.
//
//   port group   dir  tdata (low bit up)                     tuser (low bit up)
//   s_axis       in   branch_address[31:0], taken, 7'b0      operation, conditional
//   m_axis       out  prediction, 7'b0                       -
//
// For each item the block accepts it and reads the local history and both global tables,
// reads the local counter selected by that history, then predicts and, for a conditional
// branch with the operation bit set, writes back. The next item is accepted in the cycle
// after write-back at the earliest. After reset a clearing pass zeroes all tables, and no
// item is accepted during it. A stalled result holds the block in its last step.
module tournament_branch_predictor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // branch_address[31:0], taken, zero fill
  input  logic [1:0]  s_axis_tuser,  // operation, conditional
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // prediction, zero fill
);
  import tbp_pkg::*;

  state_e            state_q, state_d;
  logic [CLR_W-1:0]  clr_q;
  logic              op_q, cond_q, taken_q;
  logic              out_valid_q, out_pred_q;
  logic              accept, advance;
  logic [LIDX_W-1:0] lhist;
  logic [2:0]        lcnt;
  logic [GIDX_W-1:0] path;
  logic [1:0]        gcnt, ccnt, ccnt_new;
  logic              lpred, gpred, pred, upd;
  lcl_wr_t           lwr;
  glb_wr_t           gwr;
  logic [LIDX_W-1:0] s_axis_tdata_row_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = (state_q == ST_CNT) && (!out_valid_q || m_axis_tready);

  assign lpred = lcnt > LOCAL_TAKEN_ABOVE;
  assign gpred = gcnt > TWO_BIT_TAKEN_ABOVE;
  assign pred  = cond_q ? ((ccnt > TWO_BIT_TAKEN_ABOVE) ? lpred : gpred) : 1'b1;
  assign upd   = advance && cond_q && op_q;

  always_comb begin
    ccnt_new = ccnt;
    if (lpred == taken_q && gpred != taken_q) begin
      ccnt_new = sat2(ccnt, 1'b1);
    end else if (lpred != taken_q && gpred == taken_q) begin
      ccnt_new = sat2(ccnt, 1'b0);
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      lwr.en    = 1'b1;
      lwr.row   = clr_q[LIDX_W-1:0];
      lwr.hist  = '0;
      lwr.cidx  = clr_q[LIDX_W-1:0];
      lwr.cnt   = '0;
      gwr.en    = 1'b1;
      gwr.idx   = clr_q[GIDX_W-1:0];
      gwr.gcnt  = '0;
      gwr.ccnt  = '0;
      gwr.shift = 1'b0;
      gwr.taken = 1'b0;
    end else begin
      lwr.en    = upd;
      lwr.row   = s_axis_tdata_row_q;
      lwr.hist  = {lhist[LIDX_W-2:0], taken_q};
      lwr.cidx  = lhist;
      lwr.cnt   = sat3(lcnt, taken_q);
      gwr.en    = upd;
      gwr.idx   = path;
      gwr.gcnt  = sat2(gcnt, taken_q);
      gwr.ccnt  = ccnt_new;
      gwr.shift = 1'b1;
      gwr.taken = taken_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_axis_tdata_row_q <= s_axis_tdata[LIDX_W+1:2];
      taken_q            <= s_axis_tdata[ADDR_W];
      op_q               <= s_axis_tuser[0];
      cond_q             <= s_axis_tuser[1];
    end
    if (advance) begin
      out_pred_q <= pred;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_HIST;
      ST_HIST:  state_d = ST_CNT;
      ST_CNT:   if (advance) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  tbp_local u_local (
    .clk_i     (clk_i),
    .hist_rd_i (accept),
    .row_i     (s_axis_tdata[LIDX_W+1:2]),
    .cnt_rd_i  (state_q == ST_HIST),
    .wr_i      (lwr),
    .hist_o    (lhist),
    .cnt_o     (lcnt)
  );

  tbp_global u_global (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (accept),
    .wr_i   (gwr),
    .path_o (path),
    .gcnt_o (gcnt),
    .ccnt_o (ccnt)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_pred_q};

`ifndef ASSERT_OFF
  a_accept_to_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_HIST)
    else $error("accepted item did not move to the history read step");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("input ready during the clearing pass");

  a_write_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lwr.en |-> (state_q == ST_CLEAR || state_q == ST_CNT))
    else $error("table write outside clearing or write-back");

  a_uncond_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !cond_q) |=> (m_axis_tvalid && m_axis_tdata[0]))
    else $error("unconditional branch not predicted taken");

  a_uncond_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT && !cond_q) |-> !gwr.en)
    else $error("unconditional branch wrote the global tables");
`endif

endmodule
